// ===== src/csvrs_pkg.sv =====
package csvrs_pkg;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] CH_CR           = 8'h0D;
    localparam logic [7:0] CH_LF           = 8'h0A;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [1:0] EV_BYTE       = 2'd0;
    localparam logic [1:0] EV_FIELD_END  = 2'd1;
    localparam logic [1:0] EV_RECORD_END = 2'd2;
    localparam logic [1:0] EV_TEXT_END   = 2'd3;

    localparam int ADDR_W = 3;
    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_QUOTE     = 1'b1;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic record_started;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] field_byte;
        logic       text_done;
        logic       unterminated;
    } parse_result_t;

endpackage

// ===== src/csvrs_step.sv =====
module csvrs_step
    import csvrs_pkg::*;
(
    input  parse_state_t  state,
    input  logic          opcode,
    input  logic [7:0]    text_byte,
    input  logic [7:0]    separator_char,
    input  logic [7:0]    quote_char,
    output parse_state_t  state_next,
    output logic          result_valid,
    output parse_result_t result
);

    always_comb
    begin
        logic unquoted;
        unquoted     = 1'b0;
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;
        if (opcode == OP_END)
        begin
            result_valid        = 1'b1;
            result.event_kind   = state.record_started ? EV_RECORD_END : EV_TEXT_END;
            result.text_done    = 1'b1;
            result.unterminated = state.in_quotes && !state.quote_pending;
            state_next          = '0;
        end
        else
        begin
            unquoted = 1'b1;
            if (state.in_quotes)
            begin
                unquoted = 1'b0;
                if (state.quote_pending)
                begin
                    state_next.quote_pending = 1'b0;
                    if (text_byte == quote_char)
                    begin
                        result_valid      = 1'b1;
                        result.event_kind = EV_BYTE;
                        result.field_byte = text_byte;
                    end
                    else
                    begin
                        state_next.in_quotes = 1'b0;
                        unquoted             = 1'b1;
                    end
                end
                else if (text_byte == quote_char)
                begin
                    state_next.quote_pending = 1'b1;
                end
                else
                begin
                    result_valid      = 1'b1;
                    result.event_kind = EV_BYTE;
                    result.field_byte = text_byte;
                end
            end
            if (unquoted)
            begin
                if (text_byte == quote_char)
                begin
                    state_next.in_quotes      = 1'b1;
                    state_next.record_started = 1'b1;
                end
                else if (text_byte == separator_char)
                begin
                    state_next.record_started = 1'b1;
                    result_valid              = 1'b1;
                    result.event_kind         = EV_FIELD_END;
                end
                else if (text_byte == CH_CR)
                begin
                    result_valid = 1'b0;
                end
                else if (text_byte == CH_LF)
                begin
                    if (state.record_started)
                    begin
                        state_next.record_started = 1'b0;
                        result_valid              = 1'b1;
                        result.event_kind         = EV_RECORD_END;
                    end
                end
                else
                begin
                    state_next.record_started = 1'b1;
                    result_valid              = 1'b1;
                    result.event_kind         = EV_BYTE;
                    result.field_byte         = text_byte;
                end
            end
        end
    end

endmodule

// ===== src/csv_record_splitter.sv =====
// Channel   Direction  tdata           tuser                               tlast
// s_axis    in         text_byte[7:0]  opcode[0]                           -
// m_axis    out        field_byte[7:0] event_kind[1:0], unterminated[2]    text_done
// apb       in/out     separator_char at 0x0, quote_char at 0x4
//
// One request is accepted per cycle while m_axis is not stalled; each goes through an
// input register and then through the parse logic into the output register. The state
// update is three flag bits, done in that single pass through the parse logic.
// rst_n clears the parser state and the pipeline and restores the default characters.
// A stall on m_axis holds the input register; s_axis stalls only when both are full.
module csv_record_splitter
    import csvrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // text_byte[7:0]
    input  logic [0:0]        s_axis_tuser,   // opcode[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // field_byte[7:0]
    output logic [2:0]        m_axis_tuser,   // event_kind[1:0], unterminated[2]
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0]    separator_reg;
    logic [7:0]    quote_reg;
    logic          in_valid_reg;
    logic          in_op_reg;
    logic [7:0]    in_byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    parse_result_t out_reg;
    logic          step_valid;
    parse_result_t step_result;
    logic          out_free;
    logic          in_fire;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[1:0] != 2'b00) ? 32'd0 :
                       (paddr[2] == REG_QUOTE) ? {24'd0, quote_reg} : {24'd0, separator_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEPARATOR_RESET;
            quote_reg     <= QUOTE_RESET;
        end
        else if (cfg_write && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_SEPARATOR)
            begin
                separator_reg <= pwdata[7:0];
            end
            else
            begin
                quote_reg <= pwdata[7:0];
            end
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_fire       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_byte_reg <= s_axis_tdata;
        end
    end

    csvrs_step u_step (
        .state          (state_reg),
        .opcode         (in_op_reg),
        .text_byte      (in_byte_reg),
        .separator_char (separator_reg),
        .quote_char     (quote_reg),
        .state_next     (state_next),
        .result_valid   (step_valid),
        .result         (step_result)
    );

    assign out_valid_next = out_free ? (in_fire && step_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_valid)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.field_byte;
    assign m_axis_tuser  = {out_reg.unterminated, out_reg.event_kind};
    assign m_axis_tlast  = out_reg.text_done;

`ifndef SYNTHESIS
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_op_reg == OP_END |=> state_reg == '0)
        else $error("parser state not cleared after end of text");

    a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.quote_pending |-> state_reg.in_quotes)
        else $error("pending quote outside a quoted section");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser[1:0] == EV_RECORD_END || m_axis_tuser[1:0] == EV_TEXT_END))
        else $error("end of text carries a wrong event kind");

    a_unterm_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
        else $error("unterminated flag outside end of text");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import csvrs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 45;

    class csv_event_checker;
        logic [7:0] sep_ch;
        logic [7:0] quote_ch;
        logic quoted;
        logic quote_held;
        logic rec_open;
        parse_result_t expected_events[$];
        int errors;

        function new();
            sep_ch = SEPARATOR_RESET;
            quote_ch = QUOTE_RESET;
            quoted = 1'b0;
            quote_held = 1'b0;
            rec_open = 1'b0;
            errors = 0;
        endfunction

        function void set_char(logic reg_sel, logic [7:0] value);
            if (reg_sel == REG_SEPARATOR)
                sep_ch = value;
            else
                quote_ch = value;
        endfunction

        // Returns 1 when the request produces an event, which is then placed in ev.
        function bit predict_event(logic op, logic [7:0] c, output parse_result_t ev);
            ev = '0;
            ev.event_kind = EV_BYTE;
            if (op == OP_END)
            begin
                ev.event_kind = rec_open ? EV_RECORD_END : EV_TEXT_END;
                ev.text_done = 1'b1;
                ev.unterminated = quoted && !quote_held;
                quoted = 1'b0;
                quote_held = 1'b0;
                rec_open = 1'b0;
                return 1'b1;
            end
            if (quoted)
            begin
                if (quote_held)
                begin
                    quote_held = 1'b0;
                    if (c == quote_ch)
                    begin
                        ev.field_byte = c;
                        return 1'b1;
                    end
                    // A lone quote closes the section and the byte is parsed unquoted.
                    quoted = 1'b0;
                end
                else if (c == quote_ch)
                begin
                    quote_held = 1'b1;
                    return 1'b0;
                end
                else
                begin
                    ev.field_byte = c;
                    return 1'b1;
                end
            end
            if (c == quote_ch)
            begin
                quoted = 1'b1;
                rec_open = 1'b1;
                return 1'b0;
            end
            if (c == sep_ch)
            begin
                rec_open = 1'b1;
                ev.event_kind = EV_FIELD_END;
                return 1'b1;
            end
            if (c == CH_CR)
                return 1'b0;
            if (c == CH_LF)
            begin
                if (!rec_open)
                    return 1'b0;
                rec_open = 1'b0;
                ev.event_kind = EV_RECORD_END;
                return 1'b1;
            end
            rec_open = 1'b1;
            ev.field_byte = c;
            return 1'b1;
        endfunction

        function void note_request(logic op, logic [7:0] c);
            parse_result_t ev;
            if (predict_event(op, c, ev))
                expected_events = {expected_events, ev};
        endfunction

        function void check_result(parse_result_t got);
            parse_result_t want;
            if (expected_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected event: kind %0d byte %02h done %0b unterm %0b",
                             got.event_kind, got.field_byte, got.text_done,
                             got.unterminated);
                return;
            end
            want = expected_events.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("Event mismatch: expected kind %0d byte %02h done %0b unterm %0b, got kind %0d byte %02h done %0b unterm %0b",
                             want.event_kind, want.field_byte, want.text_done,
                             want.unterminated, got.event_kind, got.field_byte,
                             got.text_done, got.unterminated);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic [0:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    csv_event_checker board;
    logic steady;
    int sent_count;
    int cycle_count;

    csv_record_splitter dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function logic [7:0] plain_char();
        logic [7:0] b;
        do
        begin
            if ($urandom_range(0, 4) != 0)
                b = 8'($urandom_range(32, 126));
            else
                b = 8'($urandom_range(0, 255));
        end
        while (b == board.sep_ch || b == board.quote_ch || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function logic [7:0] mixed_char();
        case ($urandom_range(0, 7))
            0: return board.sep_ch;
            1: return board.quote_ch;
            2: return CH_CR;
            3: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_end();
        send_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every expected event has arrived and the
    // pipeline has had time to settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_char(reg_sel, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_record();
        int n_fields;
        int n_bytes;
        logic [7:0] b;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                send_byte(board.sep_ch);
            n_bytes = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte(board.quote_ch);
                for (int i = 0; i < n_bytes; i++)
                begin
                    b = mixed_char();
                    send_byte(b);
                    if (b == board.quote_ch)
                        send_byte(b);
                end
                if ($urandom_range(0, 7) != 0)
                    send_byte(board.quote_ch);
            end
            else
            begin
                for (int i = 0; i < n_bytes; i++)
                    send_byte(plain_char());
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            5, 6, 7: send_byte(CH_LF);
            8: send_end();
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] sep, input logic [7:0] quote, input bit calm);
        int start;
        int r;
        apb_write(REG_SEPARATOR, sep);
        apb_write(REG_QUOTE, quote);
        steady = calm;
        start = sent_count;
        while (sent_count - start < ITEMS_PER_PHASE)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                send_record();
            else if (r < 9)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(mixed_char());
            end
            else
                send_end();
        end
        send_end();
        steady = 1'b0;
        drain();
    endtask

    always @(posedge clk)
    begin
        parse_result_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.event_kind = m_axis_tuser[1:0];
                got.unterminated = m_axis_tuser[2];
                got.field_byte = m_axis_tdata;
                got.text_done = m_axis_tlast;
                board.check_result(got);
            end
        end
    end

    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        board = new();
        steady = 1'b0;
        sent_count = 0;
        cycle_count = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        s_axis_tuser <= OP_BYTE;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default characters: doubled and closing quotes, CR and LF handling,
        // a quote opening mid-field, and every way the text can end.
        send_byte("a");
        send_byte(",");
        send_byte("\"");
        send_byte("x");
        send_byte("\"");
        send_byte("\"");
        send_byte("\"");
        send_byte(",");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte("b");
        send_byte("\"");
        send_byte("y");
        send_byte("\"");
        send_item(OP_END, 8'hFF);
        send_item(OP_END, 8'h00);
        send_byte("\"");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_end();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_LF);
        drain();

        run_phase(8'h3B, 8'h27, 1'b0);
        run_phase(8'h00, 8'hFF, 1'b1);
        run_phase(8'hFF, 8'h00, 1'b0);
        run_phase(8'h7C, 8'h7C, 1'b0);
        run_phase(CH_CR, 8'h22, 1'b0);
        run_phase(CH_LF, 8'h27, 1'b0);
        run_phase(SEPARATOR_RESET, QUOTE_RESET, 1'b0);

        board.errors += board.expected_events.size();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/csvrs_pkg.sv
src/csvrs_step.sv
src/csv_record_splitter.sv
verif/tb_top.sv
